// ===== rtl/pfgb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Page framebuffer glyph blit package
// Screen geometry, command and status codes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pfgb_pkg;

  localparam int SCREEN_COLUMNS = 128;
  localparam int SCREEN_PAGES   = 8;
  localparam int SCREEN_ROWS    = 8 * SCREEN_PAGES;
  localparam int STORE_BYTES    = SCREEN_COLUMNS * SCREEN_PAGES;
  localparam int ADDR_W         = $clog2(STORE_BYTES);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PLACE = 2'd1,
    CMD_BYTE  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_REJECT  = 2'd1,
    STAT_IGNORED = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MERGE_LO,
    S_MERGE_HI,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic clr_start;
    logic clr_step;
    logic wr_lo;
    logic rd_hi;
    logic wr_hi;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic active;
    logic hi_pend;
    logic clr_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/pfgb_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Glyph blit controller
// Sequences the clearing sweep, the read-modify-write of up to two store
// bytes per glyph byte and the loading of the result register.
// ----------------------------------------------------------------------------
module pfgb_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire pfgb_pkg::cmd_t     in_command,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output pfgb_pkg::dp_cmd_t       dp_cmd,
  input  wire pfgb_pkg::dp_stat_t dp_stat
);
  import pfgb_pkg::*;

  state_t state_r, state_nxt;
  logic   boot_r, boot_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      boot_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      boot_r      <= boot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    state_nxt = state_r;
    boot_nxt  = boot_r;
    dp_cmd    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.accept = 1'b1;
          unique case (in_command)
            CMD_CLEAR: begin
              dp_cmd.clr_start = 1'b1;
              state_nxt        = S_CLEAR;
            end
            CMD_BYTE: state_nxt = dp_stat.active ? S_MERGE_LO : S_DONE;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        dp_cmd.clr_step = 1'b1;
        if (dp_stat.clr_last) begin
          if (boot_r) begin
            boot_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_MERGE_LO: begin
        dp_cmd.wr_lo = 1'b1;
        if (dp_stat.hi_pend) begin
          dp_cmd.rd_hi = 1'b1;
          state_nxt    = S_MERGE_HI;
        end else if (out_free) begin
          dp_cmd.load_out = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MERGE_HI: begin
        dp_cmd.wr_hi = 1'b1;
        if (out_free) begin
          dp_cmd.load_out = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          dp_cmd.load_out = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = dp_cmd.load_out || (out_valid_r && out_stall);
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/pfgb_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Glyph blit datapath
// Holds the frame store, the placement registers and counters, the band
// geometry and merge logic, and the result register.
// ----------------------------------------------------------------------------
module pfgb_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pfgb_pkg::dp_cmd_t  dp_cmd,
  output pfgb_pkg::dp_stat_t      dp_stat,
  input  wire pfgb_pkg::cmd_t     in_command,
  input  wire logic [6:0]         in_pos_x,
  input  wire logic [5:0]         in_pos_y,
  input  wire logic [7:0]         in_glyph_width,
  input  wire logic [6:0]         in_glyph_height,
  input  wire logic               in_invert,
  input  wire logic [7:0]         in_glyph_data,
  input  wire logic [2:0]         in_read_page,
  input  wire logic [6:0]         in_read_column,
  output logic [7:0]              out_read_data,
  output logic [1:0]              out_status
);
  import pfgb_pkg::*;

  logic [7:0]        mem [STORE_BYTES];
  logic [7:0]        rdata_r;

  logic [6:0]        origin_x_r;
  logic [5:0]        origin_y_r;
  logic [7:0]        cols_r;
  logic [6:0]        rows_r;
  logic              inv_r;
  logic [7:0]        col_cnt_r;
  logic [3:0]        band_cnt_r;
  logic              active_r;

  logic [ADDR_W-1:0] clr_addr_r;
  logic [ADDR_W-1:0] lo_addr_r, hi_addr_r;
  logic [7:0]        lo_mask_r, lo_bits_r, hi_mask_r, hi_bits_r;
  logic              lo_we_r, hi_we_r;
  logic              rd_ok_r;
  stat_t             status_r;
  logic [7:0]        out_read_data_r;
  logic [1:0]        out_status_r;

  logic [7:0]        band8, row_top, left, valid, bits8;
  logic [3:0]        nvalid;
  logic [2:0]        shift;
  logic [4:0]        page;
  logic [8:0]        column;
  logic [15:0]       mask16, bits16;
  logic              col_ok, lo_ok, hi_ok;
  logic [ADDR_W-1:0] lo_addr, hi_addr, rd_addr, acc_addr;
  logic              rd_ok;
  logic [9:0]        x_end;
  logic [8:0]        y_end;
  logic              reject;
  logic [4:0]        bands, band_inc;
  logic [8:0]        col_inc;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        wdata;

  always_comb begin
    band8   = {1'b0, band_cnt_r, 3'b000};
    row_top = 8'(origin_y_r) + band8;
    left    = ({1'b0, rows_r} > band8) ? ({1'b0, rows_r} - band8) : 8'd0;
    nvalid  = (left >= 8'd8) ? 4'd8 : left[3:0];
    valid   = 8'((9'd1 << nvalid) - 9'd1);
    shift   = row_top[2:0];
    page    = row_top[7:3];
    column  = 9'(origin_x_r) + 9'(col_cnt_r);
    bits8   = (inv_r ? ~in_glyph_data : in_glyph_data) & valid;
    mask16  = 16'(valid) << shift;
    bits16  = 16'(bits8) << shift;
    col_ok  = 32'(column) < SCREEN_COLUMNS;
    lo_ok   = (|mask16[7:0]) && col_ok && (32'(page) < SCREEN_PAGES);
    hi_ok   = (|mask16[15:8]) && col_ok && (32'(page) + 1 < SCREEN_PAGES);
    lo_addr = ADDR_W'(32'(page) * SCREEN_COLUMNS + 32'(column));
    hi_addr = ADDR_W'((32'(page) + 1) * SCREEN_COLUMNS + 32'(column));
    rd_ok   = (32'(in_read_page) < SCREEN_PAGES) && (32'(in_read_column) < SCREEN_COLUMNS);
    rd_addr = ADDR_W'(32'(in_read_page) * SCREEN_COLUMNS + 32'(in_read_column));
    acc_addr = (in_command == CMD_READ) ? rd_addr : lo_addr;

    x_end  = 10'(in_pos_x) + 10'(in_glyph_width);
    y_end  = 9'(in_pos_y) + 9'(in_glyph_height);
    reject = (32'(in_pos_y) >= SCREEN_ROWS) || (32'(x_end) > SCREEN_COLUMNS) ||
             (in_glyph_height < 7'd8) || (32'(y_end) > SCREEN_ROWS);

    bands    = 5'((8'(rows_r) + 8'd7) >> 3);
    band_inc = 5'(band_cnt_r) + 5'd1;
    col_inc  = 9'(col_cnt_r) + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      cols_r     <= '0;
      rows_r     <= '0;
      inv_r      <= 1'b0;
      col_cnt_r  <= '0;
      band_cnt_r <= '0;
      active_r   <= 1'b0;
      clr_addr_r <= '0;
      lo_we_r    <= 1'b0;
      hi_we_r    <= 1'b0;
      rd_ok_r    <= 1'b0;
      status_r   <= STAT_OK;
    end else begin
      if (dp_cmd.clr_start) begin
        clr_addr_r <= '0;
      end else if (dp_cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (dp_cmd.accept) begin
        rd_ok_r  <= (in_command == CMD_READ) && rd_ok;
        lo_we_r  <= 1'b0;
        hi_we_r  <= 1'b0;
        status_r <= STAT_OK;
        unique case (in_command)
          CMD_PLACE: begin
            if (reject) begin
              status_r <= STAT_REJECT;
              active_r <= 1'b0;
            end else begin
              origin_x_r <= in_pos_x;
              origin_y_r <= in_pos_y;
              cols_r     <= in_glyph_width;
              rows_r     <= in_glyph_height;
              inv_r      <= in_invert;
              col_cnt_r  <= '0;
              band_cnt_r <= '0;
              active_r   <= (in_glyph_width != 8'd0);
            end
          end
          CMD_BYTE: begin
            if (!active_r) begin
              status_r <= STAT_IGNORED;
            end else begin
              lo_we_r <= lo_ok;
              hi_we_r <= hi_ok;
              if (col_inc >= 9'(cols_r)) begin
                col_cnt_r <= '0;
                if (band_inc >= bands) begin
                  band_cnt_r <= '0;
                  active_r   <= 1'b0;
                end else begin
                  band_cnt_r <= band_inc[3:0];
                end
              end else begin
                col_cnt_r <= col_inc[7:0];
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.accept && (in_command == CMD_BYTE)) begin
      lo_addr_r <= lo_addr;
      hi_addr_r <= hi_addr;
      lo_mask_r <= mask16[7:0];
      lo_bits_r <= bits16[7:0];
      hi_mask_r <= mask16[15:8];
      hi_bits_r <= bits16[15:8];
    end
    if (dp_cmd.load_out) begin
      out_read_data_r <= rd_ok_r ? rdata_r : 8'd0;
      out_status_r    <= status_r;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = clr_addr_r;
    wdata  = 8'd0;
    if (dp_cmd.clr_step) begin
      mem_we = 1'b1;
    end else if (dp_cmd.wr_lo) begin
      mem_we = lo_we_r;
      waddr  = lo_addr_r;
      wdata  = (rdata_r & ~lo_mask_r) | (lo_bits_r & lo_mask_r);
    end else if (dp_cmd.wr_hi) begin
      mem_we = hi_we_r;
      waddr  = hi_addr_r;
      wdata  = (rdata_r & ~hi_mask_r) | (hi_bits_r & hi_mask_r);
    end
    mem_re = dp_cmd.accept || dp_cmd.rd_hi;
    raddr  = dp_cmd.rd_hi ? hi_addr_r : acc_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_comb begin
    dp_stat.active   = active_r;
    dp_stat.hi_pend  = hi_we_r;
    dp_stat.clr_last = (clr_addr_r == ADDR_W'(STORE_BYTES - 1));
  end

  assign out_read_data = out_read_data_r;
  assign out_status    = out_status_r;

endmodule
`default_nettype wire

// ===== rtl/page_framebuffer_glyph_blit.sv =====
`default_nettype none
// Place, read and ignored glyph bytes go through S_DONE; a glyph byte merges into its
// lower page in S_MERGE_LO and, if it spans two, into its upper page in S_MERGE_HI, as
// the store has a single write port. Clear sweeps the store one byte a cycle.
// One transaction is processed at a time; a finished result waits in the output register.
// After reset the block sweeps all 1024 store bytes with in_stall high.
// ----------------------------------------------------------------------------
// Page framebuffer glyph blit
// Monochrome page-organised framebuffer with glyph placement, byte-wise
// read-modify-write drawing, clearing and byte read-back.
// ----------------------------------------------------------------------------
module page_framebuffer_glyph_blit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_command,
  input  wire logic [6:0] in_pos_x,
  input  wire logic [5:0] in_pos_y,
  input  wire logic [7:0] in_glyph_width,
  input  wire logic [6:0] in_glyph_height,
  input  wire logic       in_invert,
  input  wire logic [7:0] in_glyph_data,
  input  wire logic [2:0] in_read_page,
  input  wire logic [6:0] in_read_column,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_read_data,
  output logic [1:0]      out_status
);
  import pfgb_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  cmd_t     command;

  assign command = cmd_t'(in_command);

  pfgb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .dp_cmd     (dp_cmd),
    .dp_stat    (dp_stat)
  );

  pfgb_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .dp_cmd          (dp_cmd),
    .dp_stat         (dp_stat),
    .in_command      (command),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_glyph_width  (in_glyph_width),
    .in_glyph_height (in_glyph_height),
    .in_invert       (in_invert),
    .in_glyph_data   (in_glyph_data),
    .in_read_page    (in_read_page),
    .in_read_column  (in_read_column),
    .out_read_data   (out_read_data),
    .out_status      (out_status)
  );

endmodule
`default_nettype wire

// ===== tb/page_framebuffer_glyph_blit_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Page framebuffer glyph blit testbench
// Drives clear, place, glyph byte and read transactions into the block and
// checks every result against a shadow framebuffer that the testbench keeps
// itself. A directed part covers rejected and empty placements, aligned and
// page-straddling bands, abandoned placements and a clear in mid-glyph; a
// random part draws mostly well-formed glyphs with read-back, mixed with
// noise and cut-short glyphs, under random gaps on both channels.
// ----------------------------------------------------------------------------
module page_framebuffer_glyph_blit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfgb_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PRINT_LIMIT  = 40;

  typedef struct {
    cmd_t       command;
    logic [6:0] pos_x;
    logic [5:0] pos_y;
    logic [7:0] glyph_width;
    logic [6:0] glyph_height;
    logic       invert;
    logic [7:0] glyph_data;
    logic [2:0] read_page;
    logic [6:0] read_column;
  } blit_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    stat_t      status;
  } blit_reply_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_command = CMD_READ;
  logic [6:0] in_pos_x = '0;
  logic [5:0] in_pos_y = '0;
  logic [7:0] in_glyph_width = '0;
  logic [6:0] in_glyph_height = '0;
  logic       in_invert = 1'b0;
  logic [7:0] in_glyph_data = '0;
  logic [2:0] in_read_page = '0;
  logic [6:0] in_read_column = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_read_data;
  logic [1:0] out_status;

  logic [7:0] shadow_frame [STORE_BYTES] = '{default: 8'h00};
  logic [6:0] shadow_org_x = '0;
  logic [5:0] shadow_org_y = '0;
  logic [7:0] shadow_cols = '0;
  logic [6:0] shadow_rows = '0;
  logic       shadow_invert = 1'b0;
  logic [7:0] shadow_col_cnt = '0;
  logic [3:0] shadow_band_cnt = '0;
  logic       shadow_active = 1'b0;

  blit_reply_t expected_replies[$];
  int          error_count = 0;
  int          replies_checked = 0;
  int          items_sent = 0;
  int          accepted_by_cmd [4] = '{default: 0};
  int          rejected_places = 0;
  int          ignored_bytes = 0;
  int          cycle_count = 0;
  int          stall_left = 0;
  bit          tx_pause = 1'b0;
  bit          rx_pause = 1'b0;

  page_framebuffer_glyph_blit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_glyph_width (in_glyph_width),
    .in_glyph_height(in_glyph_height),
    .in_invert      (in_invert),
    .in_glyph_data  (in_glyph_data),
    .in_read_page   (in_read_page),
    .in_read_column (in_read_column),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .out_status     (out_status)
  );

  always #2 clk = ~clk;

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 2);
    end else if (r < 93) begin
      return $urandom_range(3, 6);
    end
    return $urandom_range(10, 30);
  endfunction

  function automatic void merge_shadow_byte(int page, int column, logic [7:0] mask,
                                            logic [7:0] bits);
    int idx;
    if (page >= SCREEN_PAGES || column >= SCREEN_COLUMNS) begin
      return;
    end
    idx = page * SCREEN_COLUMNS + column;
    shadow_frame[idx] = (shadow_frame[idx] & ~mask) | (bits & mask);
  endfunction

  function automatic blit_reply_t apply_to_shadow_frame(blit_item_t item);
    blit_reply_t reply;
    int          row_top, rows_left, nvalid, shift, page, column, bands;
    logic [7:0]  valid, bits;
    logic [15:0] mask16, bits16;
    reply = '{8'h00, STAT_OK};
    case (item.command)
      CMD_CLEAR: begin
        foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
      end
      CMD_PLACE: begin
        if (int'(item.pos_y) >= SCREEN_ROWS ||
            int'(item.pos_x) + int'(item.glyph_width) > SCREEN_COLUMNS ||
            int'(item.glyph_height) < 8 ||
            int'(item.pos_y) + int'(item.glyph_height) > SCREEN_ROWS) begin
          reply.status = STAT_REJECT;
          shadow_active = 1'b0;
          rejected_places++;
        end else begin
          shadow_org_x = item.pos_x;
          shadow_org_y = item.pos_y;
          shadow_cols = item.glyph_width;
          shadow_rows = item.glyph_height;
          shadow_invert = item.invert;
          shadow_col_cnt = '0;
          shadow_band_cnt = '0;
          shadow_active = item.glyph_width != 0;
        end
      end
      CMD_BYTE: begin
        if (!shadow_active) begin
          reply.status = STAT_IGNORED;
          ignored_bytes++;
        end else begin
          bands = (int'(shadow_rows) + 7) >> 3;
          row_top = int'(shadow_org_y) + 8 * int'(shadow_band_cnt);
          rows_left = int'(shadow_rows) - 8 * int'(shadow_band_cnt);
          nvalid = rows_left >= 8 ? 8 : (rows_left < 0 ? 0 : rows_left);
          valid = 8'((1 << nvalid) - 1);
          shift = row_top & 7;
          page = row_top >> 3;
          column = int'(shadow_org_x) + int'(shadow_col_cnt);
          bits = (shadow_invert ? ~item.glyph_data : item.glyph_data) & valid;
          mask16 = 16'(valid) << shift;
          bits16 = 16'(bits) << shift;
          if (mask16[7:0] != 0) begin
            merge_shadow_byte(page, column, mask16[7:0], bits16[7:0]);
          end
          if (mask16[15:8] != 0) begin
            merge_shadow_byte(page + 1, column, mask16[15:8], bits16[15:8]);
          end
          shadow_col_cnt++;
          if (shadow_col_cnt >= shadow_cols) begin
            shadow_col_cnt = '0;
            shadow_band_cnt++;
            if (int'(shadow_band_cnt) >= bands) begin
              shadow_band_cnt = '0;
              shadow_active = 1'b0;
            end
          end
        end
      end
      default: begin
        if (int'(item.read_page) < SCREEN_PAGES && int'(item.read_column) < SCREEN_COLUMNS) begin
          reply.read_data = shadow_frame[int'(item.read_page) * SCREEN_COLUMNS +
                                         int'(item.read_column)];
        end
      end
    endcase
    return reply;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
    end
  endtask

  task automatic check_reply(input logic [7:0] read_data, input logic [1:0] status);
    blit_reply_t want;
    if (expected_replies.size() == 0) begin
      report_mismatch($sformatf("unexpected result data %02h status %0d", read_data, status));
    end else begin
      want = expected_replies.pop_front();
      replies_checked++;
      if (read_data !== want.read_data) begin
        report_mismatch($sformatf("read_data %02h, expected %02h", read_data, want.read_data));
      end
      if (status !== want.status) begin
        report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      check_reply(out_read_data, out_status);
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (rx_pause && $urandom_range(0, 3) == 0) begin
      stall_left <= pause_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results outstanding.",
               expected_replies.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(input blit_item_t item);
    int gap;
    gap = (tx_pause && $urandom_range(0, 2) == 0) ? pause_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= item.command;
    in_pos_x <= item.pos_x;
    in_pos_y <= item.pos_y;
    in_glyph_width <= item.glyph_width;
    in_glyph_height <= item.glyph_height;
    in_invert <= item.invert;
    in_glyph_data <= item.glyph_data;
    in_read_page <= item.read_page;
    in_read_column <= item.read_column;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expected_replies.push_back(apply_to_shadow_frame(item));
    accepted_by_cmd[item.command]++;
    items_sent++;
  endtask

  function automatic blit_item_t random_item(input cmd_t command);
    blit_item_t item;
    item.command = command;
    item.pos_x = 7'($urandom);
    item.pos_y = 6'($urandom);
    item.glyph_width = 8'($urandom);
    item.glyph_height = 7'($urandom);
    item.invert = 1'($urandom);
    item.glyph_data = 8'($urandom);
    item.read_page = 3'($urandom);
    item.read_column = 7'($urandom);
    return item;
  endfunction

  task automatic send_place(input int x, input int y, input int w, input int h, input bit inv);
    blit_item_t item;
    item = random_item(CMD_PLACE);
    item.pos_x = 7'(x);
    item.pos_y = 6'(y);
    item.glyph_width = 8'(w);
    item.glyph_height = 7'(h);
    item.invert = inv;
    send_item(item);
  endtask

  task automatic send_glyph_byte(input int data);
    blit_item_t item;
    item = random_item(CMD_BYTE);
    item.glyph_data = 8'(data);
    send_item(item);
  endtask

  task automatic send_read(input int page, input int column);
    blit_item_t item;
    item = random_item(CMD_READ);
    item.read_page = 3'(page);
    item.read_column = 7'(column);
    send_item(item);
  endtask

  task automatic send_clear();
    send_item(random_item(CMD_CLEAR));
  endtask

  task automatic test_reset_state();
    send_read(7, 127);
    send_glyph_byte(8'h3C);
  endtask

  task automatic test_placement_rejects();
    send_place(100, 0, 29, 8, 1'b0);
    send_place(0, 8, 4, 64, 1'b0);
    send_place(127, 63, 255, 127, 1'b1);
    send_place(0, 0, 128, 8, 1'b0);
    send_glyph_byte(8'hFF);
    send_place(0, 0, 0, 7, 1'b0);
    send_glyph_byte(8'hFF);
    send_read(0, 0);
  endtask

  task automatic test_zero_width();
    send_place(127, 56, 0, 8, 1'b1);
    send_glyph_byte(8'h81);
  endtask

  task automatic test_aligned_band();
    send_place(127, 56, 1, 8, 1'b1);
    send_glyph_byte(8'hA5);
    send_read(7, 127);
    send_glyph_byte(8'h00);
  endtask

  task automatic test_straddling_glyph();
    send_place(1, 3, 1, 13, 1'b0);
    send_glyph_byte(8'hFF);
    send_glyph_byte(8'h81);
    send_read(0, 1);
    send_read(1, 1);
  endtask

  task automatic test_abandon_and_clear();
    send_place(20, 0, 2, 8, 1'b0);
    send_place(30, 16, 1, 8, 1'b1);
    send_clear();
    send_glyph_byte(8'h0F);
    send_read(2, 30);
  endtask

  task automatic test_random_glyphs();
    int first, r, k, gx, gy, gw, gh, nbytes;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        tx_pause = 1'($urandom);
        rx_pause = 1'($urandom);
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send_clear();
      end else if (r < 20) begin
        repeat ($urandom_range(1, 6)) send_item(random_item(cmd_t'($urandom_range(1, 3))));
      end else begin
        k = $urandom_range(0, 49);
        gw = (k == 0) ? 128 : (k < 3) ? 0 : $urandom_range(1, 6);
        if (gw == 128) begin
          gh = $urandom_range(8, 12);
        end else begin
          gh = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 64) : $urandom_range(8, 20);
        end
        gy = $urandom_range(0, 64 - gh);
        gx = $urandom_range(0, 128 - gw);
        send_place(gx, gy, gw, gh, 1'($urandom));
        nbytes = gw * ((gh + 7) / 8);
        if ($urandom_range(0, 9) == 0) begin
          nbytes = $urandom_range(0, nbytes);
        end
        repeat (nbytes) begin
          send_glyph_byte($urandom_range(0, 255));
          if ($urandom_range(0, 9) == 0) begin
            send_read($urandom_range(0, 7), $urandom_range(0, 127));
          end
        end
        if (gw != 0) begin
          repeat ($urandom_range(1, 3)) begin
            send_read($urandom_range(gy >> 3, (gy + gh - 1) >> 3),
                      $urandom_range(gx, gx + gw - 1));
          end
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_placement_rejects();
    tx_pause = 1'b1;
    rx_pause = 1'b1;
    test_zero_width();
    test_aligned_band();
    test_straddling_glyph();
    test_abandon_and_clear();
    test_random_glyphs();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d results from %0d transactions in %0d cycles.",
             replies_checked, items_sent, cycle_count);
    $display("Clears %0d, places %0d (%0d rejected), glyph bytes %0d (%0d ignored), reads %0d.",
             accepted_by_cmd[CMD_CLEAR], accepted_by_cmd[CMD_PLACE], rejected_places,
             accepted_by_cmd[CMD_BYTE], ignored_bytes, accepted_by_cmd[CMD_READ]);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
